// ===== design/euler_flux_difference_2d_assert.svh =====
`ifndef EULER_FLUX_DIFFERENCE_2D_ASSERT_SVH
`define EULER_FLUX_DIFFERENCE_2D_ASSERT_SVH
// Assertion helpers shared by the design files.
`define EFD_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lbl failed");
`define EFD_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lbl failed");
`endif

// ===== design/efd_pkg.sv =====
package efd_pkg;
  localparam int DATA_WIDTH_DEF = 48;
  localparam int FRACTION_BITS_DEF = 24;
  localparam int GAMMA_WIDTH = 26;
  localparam int GAMMA_FRAC = 24;
  localparam logic [GAMMA_WIDTH-1:0] GAMMA_RESET = 26'd23488102;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ERR_OK  = 2'd0,
    ERR_ZERO = 2'd1,
    ERR_SAT = 2'd2
  } err_t;

  typedef enum logic [0:0] {
    KIND_FLOW   = 1'b0,
    KIND_SCALAR = 1'b1
  } kind_t;
endpackage

// ===== design/efd_ram.sv =====
module efd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end
endmodule

// ===== design/efd_front.sv =====
module efd_front #(
  parameter int DATA_WIDTH = efd_pkg::DATA_WIDTH_DEF,
  parameter int ITEM_WIDTH = 1 + 10 * DATA_WIDTH,
  parameter int DEPTH = efd_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ITEM_WIDTH-1:0] in_item,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic [ITEM_WIDTH-1:0] q_item
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_v_r, out_v_nxt;
  logic          push, pop, load;
  logic [ITEM_WIDTH-1:0] rd_data;

  assign in_ready = (cnt_r != CW'(DEPTH));
  assign push = in_valid && in_ready;
  assign load = (cnt_r != '0) && (!out_v_r || q_ready);
  assign pop  = load;
  assign q_valid = out_v_r;

  efd_ram #(.WIDTH(ITEM_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .wr_en(push), .wr_addr(wp_r), .wr_data(in_item),
    .rd_addr(rp_r), .rd_data(rd_data)
  );

  logic [ITEM_WIDTH-1:0] hold_r;
  logic                  fresh_r;
  assign q_item = fresh_r ? rd_data : hold_r;

  always_comb begin
    wp_nxt = push ? ((wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt = pop ? ((rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
    out_v_nxt = load ? 1'b1 : (q_ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
      out_v_r <= 1'b0;
      fresh_r <= 1'b0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
      out_v_r <= out_v_nxt;
      fresh_r <= load;
    end
    if (fresh_r) begin
      hold_r <= rd_data;
    end
  end

  `include "euler_flux_difference_2d_assert.svh"
  `EFD_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r <= CW'(DEPTH))
  `EFD_ASSERT_NEXT(a_load_valid, load, out_v_r)
  `EFD_ASSERT_IMPL(a_no_push_full, cnt_r == CW'(DEPTH), !push)
endmodule

// ===== design/efd_back.sv =====
module efd_back #(
  parameter int DATA_WIDTH = efd_pkg::DATA_WIDTH_DEF,
  parameter int FRACTION_BITS = efd_pkg::FRACTION_BITS_DEF,
  parameter int ITEM_WIDTH = 1 + 10 * DATA_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [efd_pkg::GAMMA_WIDTH-1:0] gamma,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  logic [ITEM_WIDTH-1:0]          q_item,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [4*DATA_WIDTH+1:0]        res_data
);
  localparam int W = DATA_WIDTH;
  localparam int F = FRACTION_BITS;
  localparam int PW = 2 * W + 2;
  localparam int H = (W + 1) / 2;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE = W'(1) << F;
  localparam logic signed [W-1:0] HALF = W'(1) << (F - 1);
  localparam int NR = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_RUN = 4'b0010, S_DIV = 4'b0100, S_OUT = 4'b1000
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] d;
  } uop_t;

  function automatic uop_t u(op_t o, int a, int b, int d);
    uop_t x;
    x.op = o; x.a = 5'(a); x.b = 5'(b); x.d = 5'(d);
    return x;
  endfunction

  // regs: 0 r1 1 mx 2 my 3 e 4 dr 5 dmx 6 dmy 7 de 8 nx 9 ny 10 half 11 one 12 gam
  function automatic uop_t prog(logic [5:0] pc);
    uop_t x;
    x = u(OP_ADD, 0, 0, 31);
    unique case (pc)
      6'd0:  x = u(OP_ADD, 0, 4, 4);
      6'd1:  x = u(OP_ADD, 1, 5, 5);
      6'd2:  x = u(OP_ADD, 2, 6, 6);
      6'd3:  x = u(OP_ADD, 3, 7, 7);
      6'd4:  x = u(OP_SUB, 12, 11, 12);
      6'd5:  x = u(OP_MUL, 1, 8, 13);
      6'd6:  x = u(OP_MUL, 2, 9, 14);
      6'd7:  x = u(OP_ADD, 13, 14, 13);
      6'd8:  x = u(OP_DIV, 13, 0, 13);
      6'd9:  x = u(OP_MUL, 5, 8, 14);
      6'd10: x = u(OP_MUL, 6, 9, 15);
      6'd11: x = u(OP_ADD, 14, 15, 14);
      6'd12: x = u(OP_DIV, 14, 4, 14);
      6'd13: x = u(OP_MUL, 1, 1, 15);
      6'd14: x = u(OP_MUL, 2, 2, 16);
      6'd15: x = u(OP_ADD, 15, 16, 15);
      6'd16: x = u(OP_MUL, 10, 15, 15);
      6'd17: x = u(OP_DIV, 15, 0, 15);
      6'd18: x = u(OP_SUB, 3, 15, 15);
      6'd19: x = u(OP_MUL, 12, 15, 15);
      6'd20: x = u(OP_MUL, 5, 5, 16);
      6'd21: x = u(OP_MUL, 6, 6, 17);
      6'd22: x = u(OP_ADD, 16, 17, 16);
      6'd23: x = u(OP_MUL, 10, 16, 16);
      6'd24: x = u(OP_DIV, 16, 4, 16);
      6'd25: x = u(OP_SUB, 7, 16, 16);
      6'd26: x = u(OP_MUL, 12, 16, 16);
      6'd27: x = u(OP_MUL, 4, 14, 17);
      6'd28: x = u(OP_MUL, 0, 13, 18);
      6'd29: x = u(OP_SUB, 17, 18, 20);
      6'd30: x = u(OP_MUL, 5, 14, 17);
      6'd31: x = u(OP_MUL, 16, 8, 18);
      6'd32: x = u(OP_ADD, 17, 18, 17);
      6'd33: x = u(OP_MUL, 1, 13, 18);
      6'd34: x = u(OP_MUL, 15, 8, 19);
      6'd35: x = u(OP_ADD, 18, 19, 18);
      6'd36: x = u(OP_SUB, 17, 18, 21);
      6'd37: x = u(OP_MUL, 6, 14, 17);
      6'd38: x = u(OP_MUL, 16, 9, 18);
      6'd39: x = u(OP_ADD, 17, 18, 17);
      6'd40: x = u(OP_MUL, 2, 13, 18);
      6'd41: x = u(OP_MUL, 15, 9, 19);
      6'd42: x = u(OP_ADD, 18, 19, 18);
      6'd43: x = u(OP_SUB, 17, 18, 22);
      6'd44: x = u(OP_ADD, 7, 16, 17);
      6'd45: x = u(OP_MUL, 17, 14, 17);
      6'd46: x = u(OP_ADD, 3, 15, 18);
      6'd47: x = u(OP_MUL, 18, 13, 18);
      6'd48: x = u(OP_SUB, 17, 18, 23);
      // scalar item: s in r0, ds in r4, kept velocities in 24 (old), 25 (new)
      6'd52: x = u(OP_ADD, 0, 4, 4);
      6'd53: x = u(OP_MUL, 4, 25, 17);
      6'd54: x = u(OP_MUL, 0, 24, 18);
      6'd55: x = u(OP_SUB, 17, 18, 20);
      default: x = u(OP_ADD, 0, 0, 31);
    endcase
    return x;
  endfunction

  logic signed [W-1:0] rf_r [NR];
  logic signed [W-1:0] unold_r, unnew_r;
  state_t              st_r, st_nxt;
  logic [5:0]          pc_r;
  logic                kind_r, sat_r, zero_r;
  logic [W-1:0]        tmp_r;

  uop_t                cur;
  logic signed [W-1:0] va, vb;
  logic signed [W:0]   sum;
  logic signed [W-1:0] alu_res;
  logic                alu_sat;

  logic [PW-1:0]       prod_r;
  logic                pneg_r, phase_r;
  logic [W-1:0]        ma_r, mb_r;
  logic [2:0]          mcnt_r;
  logic [1:0]          pidx;
  logic [2*H-1:0]      ma_x, mb_x, pp;
  logic [H-1:0]        pa, pb;
  logic [PW-1:0]       pp_sh;

  logic [W+F-1:0]      dnum_r;
  logic [W-1:0]        dden_r;
  logic [W:0]          drem_r;
  logic [W+F-1:0]      dq_r;
  logic [$clog2(W+F+1)-1:0] dcnt_r;
  logic                dneg_r;
  logic [W:0]          rtry;

  assign cur = prog(pc_r);
  assign va = rf_r[cur.a];
  assign vb = rf_r[cur.b];
  assign q_ready = (st_r == S_IDLE);
  assign res_valid = (st_r == S_OUT);

  function automatic logic [W-1:0] magn(logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  logic [W:0]   lim;
  logic [PW-1:0] rnd;
  logic [PW-F-1:0] pq;
  logic [W+F-1:0] dqv;
  logic          big;
  logic [W-1:0]  mres;
  always_comb begin
    sum = '0;
    alu_res = '0;
    alu_sat = 1'b0;
    lim = '0;
    rnd = '0;
    pq = '0;
    dqv = '0;
    big = 1'b0;
    mres = '0;
    unique case (cur.op)
      OP_ADD, OP_SUB: begin
        sum = (cur.op == OP_ADD) ? ({va[W-1], va} + {vb[W-1], vb})
                                 : ({va[W-1], va} - {vb[W-1], vb});
        if (sum[W] != sum[W-1]) begin
          alu_sat = 1'b1;
          alu_res = sum[W] ? MINV : MAXV;
        end else begin
          alu_res = sum[W-1:0];
        end
      end
      OP_MUL: begin
        rnd = prod_r + (PW'(1) << (F - 1));
        pq = rnd[PW-1:F];
        lim = {2'b0, {(W-1){1'b1}}} + (W+1)'(pneg_r);
        big = (pq > (PW-F)'(lim));
        mres = pq[W-1:0];
        if (big) begin
          alu_sat = 1'b1;
          alu_res = pneg_r ? MINV : MAXV;
        end else begin
          alu_res = pneg_r ? W'(-mres) : mres;
        end
      end
      OP_DIV: begin
        dqv = dq_r;
        lim = {2'b0, {(W-1){1'b1}}} + (W+1)'(dneg_r);
        big = (dqv > (W+F)'(lim));
        if (big) begin
          alu_sat = 1'b1;
          alu_res = dneg_r ? MINV : MAXV;
        end else begin
          alu_res = dneg_r ? W'(-dqv[W-1:0]) : dqv[W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign rtry = {drem_r[W-1:0], dnum_r[W+F-1]} - {1'b0, dden_r};

  assign pidx = mcnt_r[1:0] - 2'd1;
  assign ma_x = (2*H)'(ma_r);
  assign mb_x = (2*H)'(mb_r);
  assign pa = pidx[0] ? ma_x[2*H-1:H] : ma_x[H-1:0];
  assign pb = pidx[1] ? mb_x[2*H-1:H] : mb_x[H-1:0];
  assign pp = (2*H)'(pa) * (2*H)'(pb);
  assign pp_sh = PW'(pp) << ((pidx[0] ? H : 0) + (pidx[1] ? H : 0));

  logic [W-1:0] mag_a, mag_b;
  assign mag_a = magn(va);
  assign mag_b = magn(vb);

  logic last_pc;
  assign last_pc = kind_r ? (pc_r == 6'd55) : (pc_r == 6'd48);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (q_valid) st_nxt = S_RUN;
      S_RUN: begin
        if (zero_r) st_nxt = S_OUT;
        else if (cur.op == OP_DIV && phase_r) st_nxt = S_DIV;
        else if ((cur.op == OP_ADD || cur.op == OP_SUB || phase_r) && last_pc)
          st_nxt = S_OUT;
      end
      S_DIV: if (dcnt_r == '0) st_nxt = S_RUN;
      S_OUT: if (res_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  logic wr;
  assign wr = (st_r == S_RUN) && !zero_r &&
              ((cur.op == OP_ADD) || (cur.op == OP_SUB) ||
               (cur.op == OP_MUL && mcnt_r == 3'd5) || (cur.op == OP_DIV && !phase_r &&
               dcnt_r == '0 && tmp_r[0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pc_r <= '0;
      phase_r <= 1'b0;
      unold_r <= '0;
      unnew_r <= '0;
      sat_r <= 1'b0;
      zero_r <= 1'b0;
      kind_r <= 1'b0;
      dcnt_r <= '0;
      tmp_r <= '0;
      mcnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          kind_r <= q_item[0];
          pc_r <= q_item[0] ? 6'd52 : 6'd0;
          phase_r <= 1'b0;
          sat_r <= 1'b0;
          zero_r <= 1'b0;
          tmp_r <= '0;
        end
        S_RUN: begin
          if (cur.op == OP_MUL && !zero_r) begin
            mcnt_r <= (mcnt_r == 3'd5) ? 3'd0 : mcnt_r + 3'd1;
          end
          if (wr) begin
            sat_r <= sat_r | alu_sat;
            pc_r <= pc_r + 1'b1;
            phase_r <= 1'b0;
            tmp_r <= '0;
            if (!kind_r && pc_r == 6'd0) zero_r <= (rf_r[0] == '0) || (alu_res == '0);
            if (!kind_r && last_pc) begin
              unold_r <= rf_r[13];
              unnew_r <= rf_r[14];
            end
          end else if (cur.op == OP_DIV) begin
            phase_r <= 1'b1;
            if (phase_r) dcnt_r <= ($clog2(W+F+1))'(W + F);
          end
        end
        S_DIV: begin
          if (dcnt_r != '0) begin
            dcnt_r <= dcnt_r - 1'b1;
          end else begin
            phase_r <= 1'b0;
            tmp_r <= W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && q_valid) begin
      for (int i = 0; i < 10; i++) begin
        rf_r[i] <= q_item[1 + i*W +: W];
      end
      rf_r[10] <= HALF;
      rf_r[11] <= ONE;
      if (F >= efd_pkg::GAMMA_FRAC) begin
        rf_r[12] <= ((W+40)'(gamma) << (F - efd_pkg::GAMMA_FRAC)) > (W+40)'(MAXV)
                    ? MAXV : W'((W+40)'(gamma) << (F - efd_pkg::GAMMA_FRAC));
      end else begin
        rf_r[12] <= W'(gamma >> (efd_pkg::GAMMA_FRAC - F));
      end
      rf_r[24] <= unold_r;
      rf_r[25] <= unnew_r;
      for (int i = 20; i < 24; i++) begin
        rf_r[i] <= '0;
      end
    end else if (wr) begin
      rf_r[cur.d] <= alu_res;
    end
    if (st_r == S_RUN && cur.op == OP_MUL) begin
      if (mcnt_r == 3'd0) begin
        ma_r <= mag_a;
        mb_r <= mag_b;
        pneg_r <= va[W-1] ^ vb[W-1];
        prod_r <= '0;
      end else if (mcnt_r != 3'd5) begin
        prod_r <= prod_r + pp_sh;
      end
    end
    if (st_r == S_RUN && cur.op == OP_DIV && !phase_r && tmp_r == '0) begin
      dnum_r <= (W+F)'(mag_a) << F;
      dden_r <= mag_b;
      drem_r <= '0;
      dq_r <= '0;
      dneg_r <= va[W-1] ^ vb[W-1];
    end else if (st_r == S_DIV && dcnt_r != '0) begin
      dnum_r <= dnum_r << 1;
      if (drem_r[W-1] || !rtry[W]) begin
        drem_r <= {1'b0, rtry[W-1:0]};
        dq_r <= {dq_r[W+F-2:0], 1'b1};
      end else begin
        drem_r <= {drem_r[W-1:0], dnum_r[W+F-1]};
        dq_r <= {dq_r[W+F-2:0], 1'b0};
      end
    end
    if (st_nxt == S_OUT && st_r != S_OUT) begin
      res_data[W-1:0] <= zero_r ? '0 : (wr && cur.d == 5'd20 ? alu_res : rf_r[20]);
      res_data[2*W-1:W] <= zero_r || kind_r ? '0 : rf_r[21];
      res_data[3*W-1:2*W] <= zero_r || kind_r ? '0 : rf_r[22];
      res_data[4*W-1:3*W] <= zero_r || kind_r ? '0 :
                             (wr && cur.d == 5'd23 ? alu_res : rf_r[23]);
      res_data[4*W+1:4*W] <= zero_r ? efd_pkg::ERR_ZERO :
                             ((sat_r || (wr && alu_sat)) ? efd_pkg::ERR_SAT
                                                         : efd_pkg::ERR_OK);
    end
  end

  `include "euler_flux_difference_2d_assert.svh"
  `EFD_ASSERT_IMPL(a_onehot, 1'b1, $onehot(st_r))
  `EFD_ASSERT_NEXT(a_out_hold, res_valid && !res_ready, res_valid && $stable(res_data))
  `EFD_ASSERT_IMPL(a_scalar_vel, st_r == S_OUT && kind_r, $stable(unold_r))
endmodule

// ===== design/euler_flux_difference_2d.sv =====
// A scalar item runs a shorter program than a mean-flow item, and an item
// with a zero density leaves the program early.
// Throughput: one item at a time; a mean-flow item holds the back end through
// four divides and 24 multiplies, plus output stalls.
// Reset: synchronous active-low rst_n; heat_ratio returns to 1.4,
// kept velocities clear to zero, queue empties.
module euler_flux_difference_2d #(
  parameter int DATA_WIDTH = efd_pkg::DATA_WIDTH_DEF,
  parameter int FRACTION_BITS = efd_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [efd_pkg::GAMMA_WIDTH-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        in_tuser,  // kind
  // density, momentum_x, momentum_y, total_energy, delta_density,
  // delta_momentum_x, delta_momentum_y, delta_energy, normal_x, normal_y
  input  logic [10*DATA_WIDTH-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // flux_mass, flux_momentum_x, flux_momentum_y, flux_energy, error, zero pad
  output logic [((4*DATA_WIDTH+2+7)/8)*8-1:0] out_tdata
);
  localparam int IW = 1 + 10 * DATA_WIDTH;
  localparam int OW = ((4*DATA_WIDTH+2+7)/8)*8;

  logic [efd_pkg::GAMMA_WIDTH-1:0] gamma_r;
  logic q_valid, q_ready;
  logic [IW-1:0] q_item;
  logic [4*DATA_WIDTH+1:0] res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= efd_pkg::GAMMA_RESET;
    end else if (cfg_we) begin
      gamma_r <= cfg_wdata;
    end
  end

  efd_front #(.DATA_WIDTH(DATA_WIDTH), .ITEM_WIDTH(IW)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_item({in_tdata, in_tuser}), .q_valid(q_valid), .q_ready(q_ready),
    .q_item(q_item)
  );

  efd_back #(.DATA_WIDTH(DATA_WIDTH), .FRACTION_BITS(FRACTION_BITS), .ITEM_WIDTH(IW))
  u_back (
    .clk(clk), .rst_n(rst_n), .gamma(gamma_r), .q_valid(q_valid),
    .q_ready(q_ready), .q_item(q_item), .res_valid(out_tvalid),
    .res_ready(out_tready), .res_data(res)
  );

  assign out_tdata = OW'(res);
endmodule

// ===== test/efd_flux_checker.sv =====
module efd_flux_checker
  import efd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [25:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic         in_tuser,
  input  logic [479:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [199:0] out_tdata,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [47:0] mass;
    logic [47:0] mom_x;
    logic [47:0] mom_y;
    logic [47:0] energy;
    err_t        err;
  } flux_t;

  typedef logic signed [47:0] fx_t;
  typedef logic signed [129:0] wide_t;

  localparam longint MAXV = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint MINV = -MAXV - 1;
  localparam fx_t ONE = 48'sd16777216;
  localparam fx_t HALF = 48'sd8388608;

  logic [25:0] gamma_reg;
  fx_t un_old, un_new;
  bit sat_hit;
  flux_t flux_q[$];

  function automatic fx_t clamp(input wide_t v);
    if (v > MAXV) begin
      sat_hit = 1;
      return fx_t'(MAXV);
    end
    if (v < MINV) begin
      sat_hit = 1;
      return fx_t'(MINV);
    end
    return fx_t'(v);
  endfunction

  function automatic fx_t fadd(input fx_t a, input fx_t b);
    wide_t t;
    t = a;
    t = t + b;
    return clamp(t);
  endfunction

  function automatic fx_t fsub(input fx_t a, input fx_t b);
    wide_t t;
    t = a;
    t = t - b;
    return clamp(t);
  endfunction

  function automatic wide_t magn(input fx_t a);
    wide_t t;
    t = a;
    return (t < 0) ? -t : t;
  endfunction

  function automatic fx_t fmul(input fx_t a, input fx_t b);
    wide_t m;
    m = (magn(a) * magn(b) + (130'sd1 <<< 23)) >>> 24;
    return clamp(((a < 0) != (b < 0)) ? -m : m);
  endfunction

  function automatic fx_t fdiv(input fx_t a, input fx_t b);
    wide_t q;
    bit neg;
    neg = (a < 0) != (b < 0);
    if (b == 0) begin
      sat_hit = 1;
      return neg ? fx_t'(MINV) : fx_t'(MAXV);
    end
    q = (magn(a) <<< 24) / magn(b);
    return clamp(neg ? -q : q);
  endfunction

  function automatic fx_t pressure(input fx_t gm1, input fx_t r, input fx_t mx,
                                   input fx_t my, input fx_t e);
    fx_t q;
    fx_t k;
    q = fadd(fmul(mx, mx), fmul(my, my));
    k = fdiv(fmul(HALF, q), r);
    return fmul(gm1, fsub(e, k));
  endfunction

  function automatic flux_t predict_flux(input logic kind, input logic [479:0] d);
    flux_t res;
    fx_t r1, mx, my, e, dr, nx, ny, r2, mx2, my2, e2, gm1, un1, un2, p1, p2;
    r1 = d[0 +: 48];    mx = d[48 +: 48];  my = d[96 +: 48];
    e = d[144 +: 48];   dr = d[192 +: 48]; nx = d[384 +: 48];
    ny = d[432 +: 48];
    res = '0;
    res.err = ERR_OK;
    sat_hit = 0;
    if (kind == KIND_SCALAR) begin
      r2 = fadd(r1, dr);
      res.mass = fsub(fmul(r2, un_new), fmul(r1, un_old));
    end else begin
      r2 = fadd(r1, dr);
      mx2 = fadd(mx, fx_t'(d[240 +: 48]));
      my2 = fadd(my, fx_t'(d[288 +: 48]));
      e2 = fadd(e, fx_t'(d[336 +: 48]));
      if (r1 == 0 || r2 == 0) begin
        res.err = ERR_ZERO;
      end else begin
        gm1 = fsub(clamp(wide_t'(gamma_reg)), ONE);
        un1 = fdiv(fadd(fmul(mx, nx), fmul(my, ny)), r1);
        un2 = fdiv(fadd(fmul(mx2, nx), fmul(my2, ny)), r2);
        p1 = pressure(gm1, r1, mx, my, e);
        p2 = pressure(gm1, r2, mx2, my2, e2);
        res.mass = fsub(fmul(r2, un2), fmul(r1, un1));
        res.mom_x = fsub(fadd(fmul(mx2, un2), fmul(p2, nx)),
                         fadd(fmul(mx, un1), fmul(p1, nx)));
        res.mom_y = fsub(fadd(fmul(my2, un2), fmul(p2, ny)),
                         fadd(fmul(my, un1), fmul(p1, ny)));
        res.energy = fsub(fmul(fadd(e2, p2), un2), fmul(fadd(e, p1), un1));
        un_old = un1;
        un_new = un2;
      end
    end
    if (res.err == ERR_OK && sat_hit)
      res.err = ERR_SAT;
    return res;
  endfunction

  assign pending = flux_q.size();

  always @(posedge clk) begin
    flux_t got;
    flux_t want;
    if (!rst_n) begin
      gamma_reg <= GAMMA_RESET;
      un_old = '0;
      un_new = '0;
      flux_q.delete();
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        flux_q.push_back(predict_flux(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got.mass = out_tdata[47:0];
        got.mom_x = out_tdata[95:48];
        got.mom_y = out_tdata[143:96];
        got.energy = out_tdata[191:144];
        got.err = err_t'(out_tdata[193:192]);
        if (flux_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = flux_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected mass %h mx %h my %h e %h err %0d",
                     $time, want.mass, want.mom_x, want.mom_y, want.energy, want.err);
            $display("%0t:          actual   mass %h mx %h my %h e %h err %0d",
                     $time, got.mass, got.mom_x, got.mom_y, got.energy, got.err);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we)
        gamma_reg <= cfg_wdata;
    end
  end
endmodule

// ===== test/tb_euler_flux_difference_2d.sv =====
module tb_euler_flux_difference_2d;
  timeunit 1ns;
  timeprecision 1ps;
  import efd_pkg::*;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         cfg_we = 0;
  logic [25:0]  cfg_wdata = '0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic         in_tuser = 0;
  logic [479:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [199:0] out_tdata;
  int           fail_count;
  int           pending;
  bit           stim_done = 0;

  euler_flux_difference_2d u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  efd_flux_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

  localparam logic [47:0] PMAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] PMIN = 48'h8000_0000_0000;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // drop ready at random; once in a while hold off long so the input queue fills
  initial begin
    int hold;
    int cnt;
    hold = 0;
    cnt = 0;
    forever begin
      @(posedge clk);
      cnt++;
      if (hold > 0) begin
        hold--;
        out_tready <= 0;
      end else if (cnt == 3000 || $urandom_range(0, 9999) == 0) begin
        hold = $urandom_range(400, 700);
        out_tready <= 0;
      end else if (cnt % 2000 < 300) begin
        out_tready <= 1;
      end else begin
        out_tready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  task automatic send_request(input logic kind, input logic [479:0] d);
    int g;
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_gamma(input logic [25:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [47:0] rnd_full();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rnd_near(input int span_bits);
    logic signed [47:0] v;
    v = $signed({16'b0, $urandom}) % (48'sd1 <<< span_bits);
    return v;
  endfunction

  function automatic logic [479:0] flow_item();
    logic [479:0] d;
    d[0 +: 48] = 48'($urandom_range(32'h0040_0000, 32'h0800_0000));
    d[48 +: 48] = rnd_near(28);
    d[96 +: 48] = rnd_near(28);
    d[144 +: 48] = 48'($urandom_range(32'h0100_0000, 32'h4000_0000));
    d[192 +: 48] = rnd_near(22);
    d[240 +: 48] = rnd_near(23);
    d[288 +: 48] = rnd_near(23);
    d[336 +: 48] = rnd_near(24);
    d[384 +: 48] = rnd_near(25);
    d[432 +: 48] = rnd_near(25);
    return d;
  endfunction

  function automatic logic [479:0] noise_item();
    logic [479:0] d;
    for (int i = 0; i < 10; i++)
      d[i*48 +: 48] = rnd_full();
    return d;
  endfunction

  task automatic random_phase(input int n);
    logic [479:0] d;
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 55) begin
        send_request(KIND_FLOW, flow_item());
      end else if (p < 80) begin
        d = flow_item();
        d[0 +: 48] = rnd_near(30);
        d[192 +: 48] = rnd_near(24);
        send_request(KIND_SCALAR, d);
      end else if (p < 85) begin
        d = flow_item();
        if (p < 83) d[0 +: 48] = '0;
        else d[192 +: 48] = -d[0 +: 48];
        send_request(KIND_FLOW, d);
      end else begin
        send_request(logic'($urandom_range(0, 1)), noise_item());
      end
    end
  endtask

  task automatic directed_part();
    logic [479:0] d;
    d = flow_item();
    send_request(KIND_SCALAR, d);
    send_request(KIND_FLOW, d);
    send_request(KIND_SCALAR, d);
    send_request(KIND_FLOW, {10{PMAX}});
    send_request(KIND_FLOW, {10{PMIN}});
    send_request(KIND_SCALAR, {10{PMAX}});
    send_request(KIND_SCALAR, {10{PMIN}});
    d = flow_item();
    d[0 +: 48] = '0;
    send_request(KIND_FLOW, d);
    d = flow_item();
    d[192 +: 48] = -d[0 +: 48];
    send_request(KIND_FLOW, d);
    d = flow_item();
    d[0 +: 48] = PMAX;
    d[192 +: 48] = PMAX;
    send_request(KIND_FLOW, d);
    d = flow_item();
    d[384 +: 96] = '0;
    send_request(KIND_FLOW, d);
    d = flow_item();
    d[0 +: 48] = -d[0 +: 48];
    send_request(KIND_FLOW, d);
    d = flow_item();
    d[0 +: 48] = 48'd1;
    send_request(KIND_FLOW, d);
    send_request(KIND_SCALAR, d);
    send_request(KIND_FLOW, '0);
    send_request(KIND_SCALAR, '0);
    d = flow_item();
    d[48 +: 96] = {PMIN, PMAX};
    send_request(KIND_FLOW, d);
    send_request(KIND_SCALAR, d);
  endtask

  initial begin
    logic [25:0] gammas[6];
    gammas = '{26'd16777216, 26'd50331648, 26'd0, 26'h3FF_FFFF,
               26'($urandom_range(16777216, 50331648)), GAMMA_RESET};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    directed_part();
    random_phase(250);
    foreach (gammas[i]) begin
      drain();
      write_gamma(gammas[i]);
      if (i < 2) directed_part();
      random_phase(220);
    end
    drain();
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/efd_pkg.sv
design/efd_ram.sv
design/efd_front.sv
design/efd_back.sv
design/euler_flux_difference_2d.sv
test/efd_flux_checker.sv
test/tb_euler_flux_difference_2d.sv
